[rtl/mosa_pkg.sv]
// Shared types and codes for the median-of-two-sorted-lists block.
// Request and result payload structs, command and status codes. No dependencies.
`default_nettype none

package mosa_pkg;

  localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPUTE       = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [32:0] median_doubled;
    logic        [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

[rtl/median_of_two_sorted_arrays.sv]
// Append requests: one per cycle while in_stall_o is low, no result. Compute request:
// binary search over the shorter list, each probe stepping through S_MID, S_RD0,
// S_RD1 and S_DEC via the one read port of each list store; P <= floor(log2(m+1))+1
// probes (m = shorter count). Stall is high during a compute, and for a new compute
// while a result is pending. Both lists empty: result in the next cycle. Reset
// clears counts and control state, not list stores; reads past a length go unused.
`default_nettype none

module median_of_two_sorted_arrays #(
  parameter int MAX_LEN = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  mosa_pkg::req_t    in_req_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output mosa_pkg::res_t    out_res_o
);
  import mosa_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [2:0] {S_IDLE, S_MID, S_RD0, S_RD1, S_DEC, S_FIN} state_e;

  state_e              state_q;
  logic [CW-1:0]       cnt0_q, cnt1_q;
  logic                ovf_q;
  logic                swap_q, odd_q;
  logic [CW-1:0]       m_q, n_q, half_q, i_q, j_q;
  logic signed [CW:0]  lo_q, hi_q;
  logic        [1:0]   sts_q;
  logic signed [31:0]  al_q, br_q, ar_q, bl_q;
  logic                out_valid_q;
  res_t                out_res_q;

  logic signed [31:0]  mem0 [MAX_LEN];
  logic signed [31:0]  mem1 [MAX_LEN];
  logic signed [31:0]  rd0_q, rd1_q;

  logic                in_acc;
  logic                full0, full1, we0, we1;
  logic [CW:0]         tot;
  logic [CW+1:0]       mid_sum;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       addr_a, addr_b;
  logic [AW-1:0]       ra0, ra1;
  logic signed [31:0]  a_rd, b_rd;
  logic                al_ok, ar_ok, bl_ok, br_ok;
  logic                go_hi, go_lo;
  logic signed [CW:0]  nlo, nhi;
  logic signed [31:0]  right_v, left_v;
  logic signed [32:0]  med_v;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && in_req_i.cmd == CMD_COMPUTE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  assign full0 = (cnt0_q == CW'(MAX_LEN));
  assign full1 = (cnt1_q == CW'(MAX_LEN));
  assign we0   = in_acc && in_req_i.cmd == CMD_APPEND_FIRST && !full0;
  assign we1   = in_acc && in_req_i.cmd == CMD_APPEND_SECOND && !full1;
  assign tot   = {1'b0, cnt0_q} + {1'b0, cnt1_q};

  assign mid_sum = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    if (state_q == S_RD1) begin
      addr_a = i_q;
      addr_b = j_q - CW'(1);
    end else begin
      addr_a = i_q - CW'(1);
      addr_b = j_q;
    end
    ra0  = swap_q ? addr_b[AW-1:0] : addr_a[AW-1:0];
    ra1  = swap_q ? addr_a[AW-1:0] : addr_b[AW-1:0];
    a_rd = swap_q ? rd1_q : rd0_q;
    b_rd = swap_q ? rd0_q : rd1_q;
  end

  assign al_ok = (i_q != '0);
  assign ar_ok = (i_q < m_q);
  assign bl_ok = (j_q != '0);
  assign br_ok = (j_q < n_q);
  assign go_hi = al_ok && br_ok && (al_q > br_q);
  assign go_lo = !go_hi && bl_ok && ar_ok && (b_rd > a_rd);
  assign nhi   = $signed({1'b0, i_q}) - $signed((CW+1)'(1));
  assign nlo   = $signed({1'b0, i_q}) + $signed((CW+1)'(1));

  always_comb begin
    if (ar_ok && br_ok) begin
      right_v = (ar_q < br_q) ? ar_q : br_q;
    end else if (ar_ok) begin
      right_v = ar_q;
    end else begin
      right_v = br_q;
    end
    if (al_ok && bl_ok) begin
      left_v = (al_q > bl_q) ? al_q : bl_q;
    end else if (al_ok) begin
      left_v = al_q;
    end else begin
      left_v = bl_q;
    end
    if (odd_q) begin
      med_v = {right_v, 1'b0};
    end else begin
      med_v = {left_v[31], left_v} + {right_v[31], right_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[cnt0_q[AW-1:0]] <= in_req_i.value;
    end
    rd0_q <= mem0[ra0];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[cnt1_q[AW-1:0]] <= in_req_i.value;
    end
    rd1_q <= mem1[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      ovf_q       <= 1'b0;
      swap_q      <= 1'b0;
      odd_q       <= 1'b0;
      m_q         <= '0;
      n_q         <= '0;
      half_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      sts_q       <= ST_OK;
      al_q        <= '0;
      br_q        <= '0;
      ar_q        <= '0;
      bl_q        <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_req_i.cmd)
              CMD_APPEND_FIRST: begin
                if (full0) begin
                  ovf_q <= 1'b1;
                end else begin
                  cnt0_q <= cnt0_q + CW'(1);
                end
              end
              CMD_APPEND_SECOND: begin
                if (full1) begin
                  ovf_q <= 1'b1;
                end else begin
                  cnt1_q <= cnt1_q + CW'(1);
                end
              end
              CMD_COMPUTE: begin
                cnt0_q <= '0;
                cnt1_q <= '0;
                ovf_q  <= 1'b0;
                if (cnt0_q == '0 && cnt1_q == '0) begin
                  out_res_q.median_doubled <= '0;
                  out_res_q.status         <= ST_EMPTY;
                  out_valid_q              <= 1'b1;
                end else begin
                  swap_q  <= !(cnt0_q < cnt1_q);
                  m_q     <= (cnt0_q < cnt1_q) ? cnt0_q : cnt1_q;
                  n_q     <= (cnt0_q < cnt1_q) ? cnt1_q : cnt0_q;
                  half_q  <= tot[CW:1];
                  odd_q   <= tot[0];
                  lo_q    <= '0;
                  hi_q    <= {1'b0, ((cnt0_q < cnt1_q) ? cnt0_q : cnt1_q)};
                  sts_q   <= ovf_q ? ST_OVERFLOW : ST_OK;
                  state_q <= S_MID;
                end
              end
              default: ;
            endcase
          end
        end
        S_MID: begin
          i_q     <= mid;
          j_q     <= half_q - mid;
          state_q <= S_RD0;
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          al_q    <= a_rd;
          br_q    <= b_rd;
          state_q <= S_DEC;
        end
        S_DEC: begin
          ar_q <= a_rd;
          bl_q <= b_rd;
          if (go_hi) begin
            hi_q    <= nhi;
            state_q <= (lo_q > nhi) ? S_FIN : S_MID;
          end else if (go_lo) begin
            lo_q    <= nlo;
            state_q <= (nlo > hi_q) ? S_FIN : S_MID;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          out_res_q.median_doubled <= med_v;
          out_res_q.status         <= sts_q;
          out_valid_q              <= 1'b1;
          state_q                  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mosa_checker.sv]
// Port-level checks for the median-of-two-sorted-lists top level.
// Depends on mosa_pkg; bound to median_of_two_sorted_arrays below.
`default_nettype none

module mosa_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_stall_o,
  input mosa_pkg::req_t  in_req_i,
  input wire             out_valid_o,
  input wire             out_stall_i,
  input mosa_pkg::res_t  out_res_o
);
  import mosa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_append_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.cmd != CMD_COMPUTE && !out_valid_o
    |=> !out_valid_o)
    else $error("result without compute request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.status == ST_OK || out_res_o.status == ST_EMPTY ||
                     out_res_o.status == ST_OVERFLOW))
    else $error("bad status code");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == ST_EMPTY |-> out_res_o.median_doubled == '0)
    else $error("empty result not zero");

endmodule

bind median_of_two_sorted_arrays mosa_checker u_mosa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
